@@ hw/rtl/cdq_pkg.sv @@
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CountWidth = 5;

   typedef logic        [1:0]            req_code_type;
   typedef logic        [1:0]            status_code_type;
   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic        [CountWidth-1:0] count_type;

   localparam req_code_type REQ_PUSH_FRONT = 2'd0;
   localparam req_code_type REQ_PUSH_BACK  = 2'd1;
   localparam req_code_type REQ_POP_FRONT  = 2'd2;
   localparam req_code_type REQ_POP_BACK   = 2'd3;

   localparam status_code_type ST_DONE      = 2'd0;
   localparam status_code_type ST_OVERFLOW  = 2'd1;
   localparam status_code_type ST_UNDERFLOW = 2'd2;

   localparam count_type CAPACITY_RESET = 5'd16;

endpackage

@@ hw/rtl/cdq_req_if.sv @@
`timescale 1ns / 1ps

interface cdq_req_if
   import cdq_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_code_type req_type;
   value_type    push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

@@ hw/rtl/cdq_rsp_if.sv @@
`timescale 1ns / 1ps

interface cdq_rsp_if
   import cdq_pkg::*;
   ();
   logic            valid;
   logic            ready;
   status_code_type status;
   value_type       removed_value;
   value_type       front_value;
   value_type       back_value;
   count_type       item_count;
   logic            is_empty;
   logic            is_full;

   modport source (output valid, output status, output removed_value, output front_value,
                   output back_value, output item_count, output is_empty, output is_full,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input front_value,
                   input back_value, input item_count, input is_empty, input is_full,
                   output ready);
endinterface

@@ hw/rtl/cdq_mem.sv @@
`timescale 1ns / 1ps

module cdq_mem
   import cdq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  value_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output value_type                rd_data
);

   value_type mem [DEPTH];
   value_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/circular_deque_core.sv @@
`timescale 1ns / 1ps
// circular deque: push or pop at either end of a ring held in a slot memory
// result: loaded in state S_DONE, which follows S_READ after a request is accepted;
//   held back only while the previous result still waits in the output register
// requests: a new one is taken only in S_IDLE, so each passes S_READ and S_DONE;
//   the registered memory read fetches the new front or back value after a pop
// reset: queue empty (indices and count zero), capacity 16, slot contents undefined

module circular_deque_core
   import cdq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   cdq_req_if.sink           req_ch,
   cdq_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   // wide enough for both an index and a capacity plus one
   localparam int unsigned XW = ((AW > CountWidth) ? AW : CountWidth) + 1;

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request
   localparam logic [1:0] S_READ = 2'd1;   // memory read in flight
   localparam logic [1:0] S_DONE = 2'd2;   // read data valid, load result

   logic [1:0]    state_ff, state_in;

   // queue pointers and occupancy
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   count_type     count_ff, count_in;
   count_type     cap_ff, cap_in;

   // cached copies of the end values, so pushes need no read
   value_type     front_ff, front_in;
   value_type     back_ff, back_in;

   // per-request bookkeeping
   status_code_type status_ff, status_in;
   value_type       removed_ff, removed_in;
   logic            fill_front_ff, fill_front_in;
   logic            fill_back_ff, fill_back_in;
   logic [AW-1:0]   rd_addr_ff, rd_addr_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   status_code_type rsp_status_ff, rsp_status_in;
   value_type       rsp_removed_ff, rsp_removed_in;
   value_type       rsp_front_ff, rsp_front_in;
   value_type       rsp_back_ff, rsp_back_in;
   count_type       rsp_count_ff, rsp_count_in;
   logic            rsp_empty_ff, rsp_empty_in;
   logic            rsp_full_ff, rsp_full_in;

   // memory write port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     rd_data;

   logic          accept;
   logic          rsp_free;
   count_type     cap_eff;
   logic [AW-1:0] cap_last;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] tail_dec;
   logic [AW-1:0] tail_inc;
   value_type     front_cur;
   value_type     back_cur;

   // zero acts as one, values above the slot count saturate
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CountWidth'(1);
      end else if (XW'(cap_ff) > XW'(DEPTH)) begin
         cap_eff = CountWidth'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign cap_last = AW'(XW'(cap_eff) - XW'(1));

   // index moves with wrap at the capacity
   assign head_dec = (head_ff == '0) ? cap_last : AW'(head_ff - AW'(1));
   assign tail_dec = (tail_ff == '0) ? cap_last : AW'(tail_ff - AW'(1));
   assign head_inc = ((XW'(head_ff) + XW'(1)) >= XW'(cap_eff)) ? '0 : AW'(head_ff + AW'(1));
   assign tail_inc = ((XW'(tail_ff) + XW'(1)) >= XW'(cap_eff)) ? '0 : AW'(tail_ff + AW'(1));

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // end values after a pop, merged with the freshly read slot
   assign front_cur = fill_front_ff ? rd_data : front_ff;
   assign back_cur  = fill_back_ff  ? rd_data : back_ff;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      cap_in         = cap_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      fill_front_in  = fill_front_ff;
      fill_back_in   = fill_back_ff;
      rd_addr_in     = rd_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_back_in    = rsp_back_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_full_in    = rsp_full_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in     = ST_DONE;
               removed_in    = '0;
               fill_front_in = 1'b0;
               fill_back_in  = 1'b0;
               state_in      = S_READ;
               unique case (req_ch.req_type) inside
                  REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                     if (count_ff >= cap_eff) begin
                        status_in = ST_OVERFLOW;
                     end else if (count_ff == '0) begin
                        // first value always lands in slot zero
                        head_in  = '0;
                        tail_in  = '0;
                        count_in = CountWidth'(1);
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        front_in = req_ch.push_value;
                        back_in  = req_ch.push_value;
                     end else if (req_ch.req_type == REQ_PUSH_FRONT) begin
                        head_in  = head_dec;
                        count_in = count_ff + CountWidth'(1);
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        front_in = req_ch.push_value;
                     end else begin
                        tail_in  = tail_inc;
                        count_in = count_ff + CountWidth'(1);
                        wr_en    = 1'b1;
                        wr_addr  = tail_inc;
                        back_in  = req_ch.push_value;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = ST_UNDERFLOW;
                     end else if (count_ff == CountWidth'(1)) begin
                        // last value out: back to the reset layout
                        removed_in = front_ff;
                        head_in    = '0;
                        tail_in    = '0;
                        count_in   = '0;
                     end else if (req_ch.req_type == REQ_POP_FRONT) begin
                        removed_in    = front_ff;
                        head_in       = head_inc;
                        count_in      = count_ff - CountWidth'(1);
                        rd_addr_in    = head_inc;
                        fill_front_in = 1'b1;
                        fill_back_in  = (count_ff == CountWidth'(2));
                     end else begin
                        removed_in    = back_ff;
                        tail_in       = tail_dec;
                        count_in      = count_ff - CountWidth'(1);
                        rd_addr_in    = tail_dec;
                        fill_back_in  = 1'b1;
                        fill_front_in = (count_ff == CountWidth'(2));
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               front_in       = front_cur;
               back_in        = back_cur;
               fill_front_in  = 1'b0;
               fill_back_in   = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_front_in   = (count_ff != '0) ? front_cur : '0;
               rsp_back_in    = (count_ff != '0) ? back_cur : '0;
               rsp_count_in   = count_ff;
               rsp_empty_in   = (count_ff == '0);
               rsp_full_in    = (count_ff == cap_eff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a capacity write empties the queue, slot contents are left alone
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         cap_ff        <= CAPACITY_RESET;
         fill_front_ff <= 1'b0;
         fill_back_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         fill_front_ff <= fill_front_in;
         fill_back_ff  <= fill_back_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      back_ff        <= back_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rd_addr_ff     <= rd_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_back_ff    <= rsp_back_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
   end

   // slot store: push writes at accept, pop reads the new end in the cycle after accept
   cdq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.push_value),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.removed_value = rsp_removed_ff;
   assign rsp_ch.front_value   = rsp_front_ff;
   assign rsp_ch.back_value    = rsp_back_ff;
   assign rsp_ch.item_count    = rsp_count_ff;
   assign rsp_ch.is_empty      = rsp_empty_ff;
   assign rsp_ch.is_full       = rsp_full_ff;

endmodule

@@ sim/circular_deque_core_tb.sv @@
`timescale 1ns / 1ps

module circular_deque_core_tb;
   import cdq_pkg::*;

   localparam int RING_DEPTH   = 16;
   localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 50;
   localparam int SETTLE_TICKS = 10;

   // one request as the driver sees it
   typedef struct {
      req_code_type kind;
      value_type    value;
      bit           drain_first;  // hold this request back until all responses are in
   } deque_request_type;

   // one predicted response
   typedef struct {
      status_code_type status;
      value_type       removed;
      value_type       front;
      value_type       back;
      count_type       count;
      logic            empty;
      logic            full;
   } deque_outcome_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   cdq_req_if req_if ();
   cdq_rsp_if rsp_if ();

   circular_deque_core #(
      .DEPTH(RING_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // requests waiting to be driven, filled by the sequence below
   deque_request_type pending_requests[$];
   // predicted responses, oldest first
   deque_outcome_type expected_outcomes[$];

   // shadow copy of the deque
   value_type  ring_slots[RING_DEPTH];
   int         head_slot;
   int         tail_slot;
   int         fill_level;
   logic [4:0] cap_setting;

   // idling knobs, percent of cycles
   int send_idle_pct;
   int recv_stall_pct;

   // bookkeeping
   int mismatch_count;
   int requests_sent;
   int responses_seen;
   int overflow_count;
   int underflow_count;
   int peak_fill;
   int cap_writes;
   int idle_cycles;

   deque_request_type next_request;
   deque_outcome_type want;

   always #2 clock = ~clock;

   // usable slots: zero acts as one, anything above the ring size saturates
   function automatic int ring_limit();
      if (cap_setting == 5'd0) return 1;
      if (int'(cap_setting) > RING_DEPTH) return RING_DEPTH;
      return int'(cap_setting);
   endfunction

   // apply one accepted request to the shadow deque and queue its response
   function automatic void predict_request(input req_code_type kind, input value_type value);
      deque_outcome_type outcome;
      int lim;
      lim = ring_limit();
      outcome = '{status: ST_DONE, removed: '0, front: '0, back: '0, count: '0,
                  empty: 1'b0, full: 1'b0};
      if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
         if (fill_level >= lim) begin
            outcome.status = ST_OVERFLOW;
            overflow_count++;
         end else if (fill_level == 0) begin
            // first value always lands in slot zero
            head_slot = 0;
            tail_slot = 0;
            ring_slots[0] = value;
            fill_level = 1;
         end else if (kind == REQ_PUSH_FRONT) begin
            head_slot = (head_slot == 0) ? lim - 1 : head_slot - 1;
            ring_slots[head_slot] = value;
            fill_level++;
         end else begin
            tail_slot = (tail_slot + 1 >= lim) ? 0 : tail_slot + 1;
            ring_slots[tail_slot] = value;
            fill_level++;
         end
      end else begin
         if (fill_level == 0) begin
            outcome.status = ST_UNDERFLOW;
            underflow_count++;
         end else if (kind == REQ_POP_FRONT) begin
            outcome.removed = ring_slots[head_slot];
            if (fill_level == 1) begin
               head_slot = 0;
               tail_slot = 0;
               fill_level = 0;
            end else begin
               head_slot = (head_slot + 1 >= lim) ? 0 : head_slot + 1;
               fill_level--;
            end
         end else begin
            outcome.removed = ring_slots[tail_slot];
            if (fill_level == 1) begin
               head_slot = 0;
               tail_slot = 0;
               fill_level = 0;
            end else begin
               tail_slot = (tail_slot == 0) ? lim - 1 : tail_slot - 1;
               fill_level--;
            end
         end
      end
      outcome.front = (fill_level != 0) ? ring_slots[head_slot] : '0;
      outcome.back  = (fill_level != 0) ? ring_slots[tail_slot] : '0;
      outcome.count = count_type'(fill_level);
      outcome.empty = (fill_level == 0);
      outcome.full  = (fill_level == lim);
      if (fill_level > peak_fill) peak_fill = fill_level;
      expected_outcomes.insert(expected_outcomes.size(), outcome);
   endfunction

   task automatic queue_request(input req_code_type kind, input value_type value,
                                input bit drain_first);
      deque_request_type r;
      r.kind = kind;
      r.value = value;
      r.drain_first = drain_first;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // random bursts that lean toward pushes or pops so the fill level sweeps
   // between empty and full, with some evenly mixed stretches as noise
   task automatic queue_random_phase(input int n, input int lim);
      int made;
      int burst;
      int push_pct;
      int pick;
      value_type v;
      req_code_type kind;
      made = 0;
      while (made < n) begin
         burst = $urandom_range(2 * lim + 2, 1);
         pick = $urandom_range(2);
         push_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
         repeat (burst) begin
            if (made < n) begin
               if ($urandom_range(99) < push_pct)
                  kind = ($urandom_range(1) == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
               else
                  kind = ($urandom_range(1) == 0) ? REQ_POP_FRONT : REQ_POP_BACK;
               case ($urandom_range(7))
                  0: v = 32'sh7fff_ffff;
                  1: v = 32'sh8000_0000;
                  2: v = '0;
                  3: v = '1;
                  default: v = value_type'($urandom());
               endcase
               // a fixed pause point plus a few random ones
               queue_request(kind, v, made == 10 || $urandom_range(99) < 4);
               made++;
            end
         end
      end
   endtask

   // block idle: nothing pending, nothing on the wire, every response back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_outcomes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // capacity write also empties the deque, slot contents stay
   task automatic write_capacity(input logic [4:0] cap);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = cap;
      head_slot   = 0;
      tail_slot   = 0;
      fill_level  = 0;
      cap_writes++;
   endtask

   // request driver: keeps valid up until the handshake, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_request(req_if.req_type, req_if.push_value);
            requests_sent++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            // slot free: present the next request unless idling or draining
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_requests[0].drain_first && expected_outcomes.size() != 0)) begin
               next_request = pending_requests[0];
               pending_requests.delete(0);
               req_if.valid      <= 1'b1;
               req_if.req_type   <= next_request.kind;
               req_if.push_value <= next_request.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compares each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            responses_seen++;
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request outstanding: status %0d count %0d",
                           $realtime, rsp_if.status, rsp_if.item_count);
            end else begin
               want = expected_outcomes[0];
               expected_outcomes.delete(0);
               if (rsp_if.status !== want.status || rsp_if.removed_value !== want.removed ||
                   rsp_if.front_value !== want.front || rsp_if.back_value !== want.back ||
                   rsp_if.item_count !== want.count || rsp_if.is_empty !== want.empty ||
                   rsp_if.is_full !== want.full) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: response %0d mismatch", $realtime, responses_seen);
                     $display("   expected status %0d removed %h front %h back %h",
                              want.status, want.removed, want.front, want.back,
                              " count %0d empty %b full %b",
                              want.count, want.empty, want.full);
                     $display("   actual   status %0d removed %h front %h back %h",
                              rsp_if.status, rsp_if.removed_value, rsp_if.front_value,
                              rsp_if.back_value, " count %0d empty %b full %b",
                              rsp_if.item_count, rsp_if.is_empty, rsp_if.is_full);
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d responses outstanding",
                  $realtime, idle_cycles, expected_outcomes.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase_cap  [NUM_PHASES];
      int phase_send [NUM_PHASES];
      int phase_recv [NUM_PHASES];

      // capacity sweep: 31 saturates, then the reset value, one and other sizes from two to twelve
      phase_cap  = '{31, 16, 1, 7, 16, 2, 12, 9};
      phase_send = '{0, 59, 0, 26, 0, 59, 0, 26};
      phase_recv = '{0, 0, 59, 26, 0, 0, 59, 26};

      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_PUSH_FRONT;
      req_if.push_value = '0;
      rsp_if.ready      = 1'b0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      mismatch_count    = 0;
      requests_sent     = 0;
      responses_seen    = 0;
      overflow_count    = 0;
      underflow_count   = 0;
      peak_fill         = 0;
      cap_writes        = 0;
      idle_cycles       = 0;
      cap_setting       = CAPACITY_RESET;
      head_slot         = 0;
      tail_slot         = 0;
      fill_level        = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: capacity three, extreme values, both ends, both wraps
      write_capacity(5'd3);
      queue_request(REQ_PUSH_FRONT, 32'sh7fff_ffff, 1'b0);  // push into empty queue
      queue_request(REQ_PUSH_BACK,  32'sh8000_0000, 1'b0);
      queue_request(REQ_PUSH_FRONT, '1, 1'b0);              // head wraps to the top
      queue_request(REQ_PUSH_BACK,  '0, 1'b0);              // overflow
      queue_request(REQ_POP_BACK,   '0, 1'b0);
      queue_request(REQ_POP_FRONT,  '1, 1'b0);              // head wraps back to zero
      queue_request(REQ_POP_FRONT,  '0, 1'b0);              // pop of the last value
      queue_request(REQ_POP_BACK,   '0, 1'b0);              // underflow at either end
      queue_request(REQ_POP_FRONT,  '0, 1'b0);
      queue_request(REQ_PUSH_BACK,  32'sh5555_aaaa, 1'b0);
      queue_request(REQ_PUSH_BACK,  32'shaaaa_5555, 1'b0);
      queue_request(REQ_PUSH_BACK,  '0, 1'b0);
      queue_request(REQ_POP_FRONT,  '0, 1'b0);
      queue_request(REQ_PUSH_BACK,  32'sh1234_5678, 1'b0);  // tail wraps to zero
      queue_request(REQ_POP_BACK,   '0, 1'b0);              // tail wraps back to the top
      wait_until_drained();

      // capacity zero acts as one; the write must also empty the two stored values
      write_capacity(5'd0);
      queue_request(REQ_POP_FRONT,  '0, 1'b0);
      queue_request(REQ_PUSH_FRONT, 32'sh0000_0001, 1'b0);
      queue_request(REQ_PUSH_BACK,  32'sh0000_0002, 1'b0);
      queue_request(REQ_POP_BACK,   '0, 1'b0);
      queue_request(REQ_POP_FRONT,  '0, 1'b0);
      wait_until_drained();

      // random phases over capacities and idling patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(5'(phase_cap[p]));
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         queue_random_phase(PHASE_ITEMS, ring_limit());
         wait_until_drained();
      end

      repeat (SETTLE_TICKS) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $display("%0d responses never arrived", expected_outcomes.size());
         mismatch_count += expected_outcomes.size();
      end

      $display("run: %0d requests, %0d responses, %0d capacity writes, deepest fill %0d",
               requests_sent, responses_seen, cap_writes, peak_fill);
      $display("     %0d overflows and %0d underflows, %0d mismatches",
               overflow_count, underflow_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ circular_deque_core.f @@
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_req_if.sv
hw/rtl/cdq_rsp_if.sv
hw/rtl/cdq_mem.sv
hw/rtl/circular_deque_core.sv
sim/circular_deque_core_tb.sv
